// ===== design/lmsaf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmsaf_pkg
// Shared types, constants and saturation helpers of the LMS adaptive filter.
// ----------------------------------------------------------------------------
package lmsaf_pkg;

  // default filter length
  localparam int unsigned TapsDef = 8;

  // fixed field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned WeightW = 24;
  localparam int unsigned AccW    = 40;
  localparam int unsigned StepW   = 16;
  localparam int unsigned TapsW   = 4;
  localparam int unsigned MueW    = 33;  // step size times error
  localparam int unsigned DeltaW  = 49;  // step size times error times sample
  localparam int unsigned FracShift = 22;

  localparam logic [StepW-1:0] StepSizeRst = 16'd328;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_MUE,
    ST_UPD,
    ST_DRAIN
  } lmsaf_state_e;

  // clamp a 41-bit sum to the signed 40-bit accumulator range
  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW:0] x);
    logic signed [AccW-1:0] r;
    if (x[AccW] != x[AccW-1]) begin
      r = x[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = x[AccW-1:0];
    end
    return r;
  endfunction

  // clamp a 29-bit sum to the signed 24-bit weight range
  function automatic logic signed [WeightW-1:0] sat_weight(input logic signed [28:0] x);
    logic signed [WeightW-1:0] r;
    if ((&x[28:23]) || !(|x[28:23])) begin
      r = x[WeightW-1:0];
    end else begin
      r = x[28] ? {1'b1, {(WeightW-1){1'b0}}} : {1'b0, {(WeightW-1){1'b1}}};
    end
    return r;
  endfunction

  // clamp a 20-bit value to the signed 16-bit sample range
  function automatic logic signed [SampleW-1:0] sat_sample(input logic signed [19:0] x);
    logic signed [SampleW-1:0] r;
    if ((&x[19:15]) || !(|x[19:15])) begin
      r = x[SampleW-1:0];
    end else begin
      r = x[19] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/lms_adaptive_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lms_adaptive_filter
// LMS adaptive FIR weight estimator with fixed-point Q2.14 samples.
// ----------------------------------------------------------------------------
// Regressor samples arrive one per request; the request with last_element set
// also carries the desired sample and produces one result (filter output,
// a-priori error, tap count). Weights are Q2.22 in a synchronous memory next
// to a regressor memory, both single read port with a registered read.
// Each stored element passes a memory read, a multiply and a saturating
// accumulate. The last element then forms the result, scales the error by
// the step size, streams the weight read-modify-write pass at one tap per
// cycle and drains it; forming the result may wait for the result register
// to empty. Elements beyond TAPS are dropped, though a last one still forms
// the result. The result register lets the next vector start while a result
// waits. step_size may be written between vectors; restart on the first
// element zeroes all weights at once.
// ----------------------------------------------------------------------------
module lms_adaptive_filter #(
  parameter int unsigned TAPS = lmsaf_pkg::TapsDef
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  // configuration
  input  wire                                      step_size_we_i,
  input  wire  [lmsaf_pkg::StepW-1:0]               step_size_i,
  // input requests
  input  wire                                      in_valid_i,
  output logic                                     in_ready_o,
  input  wire  logic signed [lmsaf_pkg::SampleW-1:0] regressor_sample_i,
  input  wire  logic signed [lmsaf_pkg::SampleW-1:0] desired_sample_i,
  input  wire                                      last_element_i,
  input  wire                                      restart_i,
  // results
  output logic                                     out_valid_o,
  input  wire                                      out_ready_i,
  output logic signed [lmsaf_pkg::SampleW-1:0]      filter_output_o,
  output logic signed [lmsaf_pkg::SampleW-1:0]      error_value_o,
  output logic [lmsaf_pkg::TapsW-1:0]               taps_seen_o
);
  import lmsaf_pkg::*;

  localparam int unsigned CntW = $clog2(TAPS + 1);
  localparam int unsigned IdxW = (TAPS > 1) ? $clog2(TAPS) : 1;

  lmsaf_state_e state_q, state_d;

  logic [CntW-1:0]           count_q, count_d;
  logic [IdxW-1:0]           upd_idx_q, upd_idx_d;
  logic [IdxW-1:0]           addr_q;
  logic [IdxW-1:0]           rd_addr;
  logic                      rd_valid_q;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic signed [AccW-1:0]    prod_q;
  logic [StepW-1:0]          step_q;
  logic [TAPS-1:0]           wvalid_q, wvalid_d;
  logic                      out_valid_q, out_valid_d;

  logic signed [SampleW-1:0] u_q, d_q, e_q;
  logic                      last_q;
  logic signed [MueW-1:0]    mue_q;
  logic signed [SampleW-1:0] y_out_q, e_out_q;
  logic [TapsW-1:0]          taps_q;

  logic signed [SampleW-1:0] reg_mem [TAPS];
  logic signed [WeightW-1:0] w_mem [TAPS];
  logic signed [SampleW-1:0] reg_rdata_q;
  logic signed [WeightW-1:0] w_rdata_q;
  logic signed [WeightW-1:0] w_masked;

  logic                      in_acc, store, clear_w, out_load, last_issue, drained;
  logic signed [AccW:0]      y_sum;
  logic signed [18:0]        y_wide;
  logic signed [19:0]        e_wide;
  logic signed [SampleW-1:0] y_sat, e_sat;
  logic signed [SampleW:0]   mu_s;

  logic                      wr_en;
  logic [IdxW-1:0]           wr_addr;
  logic signed [WeightW-1:0] wr_data;

  // request handshake and control decode
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    in_acc     = in_valid_i && in_ready_o;
    store      = in_acc && (count_q < CntW'(TAPS));
    clear_w    = in_acc && restart_i && (count_q == '0);
    out_load   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
    last_issue = (upd_idx_q == IdxW'(count_q - CntW'(1)));
    drained    = !rd_valid_q && !wr_en;
    rd_addr    = (state_q == ST_UPD) ? upd_idx_q : IdxW'(count_q);
    w_masked   = wvalid_q[addr_q] ? w_rdata_q : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (store) begin
            state_d = ST_MUL;
          end else if (last_element_i) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = last_q ? ST_FIN : ST_IDLE;
      ST_FIN:   state_d = out_load ? ST_MUE : ST_FIN;
      ST_MUE:   state_d = ST_UPD;
      ST_UPD:   state_d = last_issue ? ST_DRAIN : ST_UPD;
      ST_DRAIN: state_d = drained ? ST_IDLE : ST_DRAIN;
      default:  state_d = ST_IDLE;
    endcase
  end

  // result rounding and error
  always_comb begin
    y_sum  = (AccW+1)'(acc_q) + (AccW+1)'(1 << (FracShift - 1));
    y_wide = y_sum[AccW:FracShift];
    e_wide = 20'(d_q) - 20'(y_wide);
    y_sat  = sat_sample(20'(y_wide));
    e_sat  = sat_sample(e_wide);
    mu_s   = {1'b0, step_q};
  end

  // control state updates
  always_comb begin
    count_d     = count_q;
    upd_idx_d   = upd_idx_q;
    acc_d       = acc_q;
    wvalid_d    = wvalid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (store) begin
      count_d = count_q + CntW'(1);
    end
    if (clear_w) begin
      wvalid_d = '0;
    end
    if (wr_en) begin
      wvalid_d[wr_addr] = 1'b1;
    end
    if (state_q == ST_ACC) begin
      acc_d = sat_acc((AccW+1)'(acc_q) + (AccW+1)'(prod_q));
    end
    if (out_load) begin
      acc_d       = '0;
      out_valid_d = 1'b1;
    end
    if (state_q == ST_MUE) begin
      upd_idx_d = '0;
    end
    if (state_q == ST_UPD) begin
      upd_idx_d = upd_idx_q + IdxW'(1);
    end
    if ((state_q == ST_DRAIN) && drained) begin
      count_d = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      upd_idx_q   <= '0;
      rd_valid_q  <= 1'b0;
      acc_q       <= '0;
      step_q      <= StepSizeRst;
      wvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      upd_idx_q   <= upd_idx_d;
      rd_valid_q  <= (state_q == ST_UPD);
      acc_q       <= acc_d;
      wvalid_q    <= wvalid_d;
      out_valid_q <= out_valid_d;
      if (step_size_we_i) begin
        step_q <= step_size_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_q <= rd_addr;
    if (in_acc) begin
      u_q    <= regressor_sample_i;
      d_q    <= desired_sample_i;
      last_q <= last_element_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= AccW'(u_q) * AccW'(w_masked);
    end
    if (out_load) begin
      y_out_q <= y_sat;
      e_out_q <= e_sat;
      e_q     <= e_sat;
      taps_q  <= TapsW'(count_q);
    end
    if (state_q == ST_MUE) begin
      mue_q <= MueW'(mu_s) * MueW'(e_q);
    end
  end

  // regressor memory
  always_ff @(posedge clk_i) begin
    if (store) begin
      reg_mem[IdxW'(count_q)] <= regressor_sample_i;
    end
    reg_rdata_q <= reg_mem[rd_addr];
  end

  // weight memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      w_mem[wr_addr] <= wr_data;
    end
    w_rdata_q <= w_mem[rd_addr];
  end

  // weight update pipeline
  lmsaf_weight_alu #(
    .IdxW(IdxW)
  ) u_weight_alu (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (rd_valid_q),
    .req_addr_i  (addr_q),
    .mue_i       (mue_q),
    .sample_i    (reg_rdata_q),
    .weight_i    (w_masked),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // result outputs
  assign out_valid_o     = out_valid_q;
  assign filter_output_o = y_out_q;
  assign error_value_o   = e_out_q;
  assign taps_seen_o     = taps_q;

endmodule
`default_nettype wire

// ===== design/lmsaf_weight_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmsaf_weight_alu
// Two-stage weight update: multiply by the scaled error, then round and
// saturate the new weight for write-back into the weight memory.
// ----------------------------------------------------------------------------
module lmsaf_weight_alu #(
  parameter int unsigned IdxW = 3
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      req_valid_i,
  input  wire  [IdxW-1:0]                          req_addr_i,
  input  wire  logic signed [lmsaf_pkg::MueW-1:0]    mue_i,
  input  wire  logic signed [lmsaf_pkg::SampleW-1:0] sample_i,
  input  wire  logic signed [lmsaf_pkg::WeightW-1:0] weight_i,
  output logic                                     wr_en_o,
  output logic [IdxW-1:0]                          wr_addr_o,
  output logic signed [lmsaf_pkg::WeightW-1:0]     wr_data_o
);
  import lmsaf_pkg::*;

  logic                      s1_valid_q;
  logic [IdxW-1:0]           s1_addr_q;
  logic signed [DeltaW-1:0]  s1_prod_q;
  logic signed [WeightW-1:0] s1_weight_q;

  logic signed [DeltaW:0]    rnd;
  logic signed [27:0]        delta;
  logic signed [28:0]        sum;

  // stage one control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_valid_i;
    end
  end

  // stage one product
  always_ff @(posedge clk_i) begin
    s1_addr_q   <= req_addr_i;
    s1_prod_q   <= DeltaW'(mue_i) * DeltaW'(sample_i);
    s1_weight_q <= weight_i;
  end

  // round to nearest, add, saturate
  always_comb begin
    rnd       = (DeltaW+1)'(s1_prod_q) + (DeltaW+1)'(1 << (FracShift - 1));
    delta     = rnd[DeltaW:FracShift];
    sum       = 29'(s1_weight_q) + 29'(delta);
    wr_data_o = sat_weight(sum);
    wr_en_o   = s1_valid_q;
    wr_addr_o = s1_addr_q;
  end

endmodule
`default_nettype wire
